FILE: rtl/triangle_binary_clock_led_mask_top_defines.svh
// Assertion macros shared by the LED mask block's checkers.
// No dependencies; each macro expects clk and rst_n in the enclosing scope.
`ifndef TRIANGLE_BINARY_CLOCK_LED_MASK_TOP_DEFINES_SVH
`define TRIANGLE_BINARY_CLOCK_LED_MASK_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TBLM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tblm check failed");

// Consequent must hold in the cycle after the antecedent.
`define TBLM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tblm check failed");

`endif

FILE: rtl/tblm_pkg.sv
// Shared types, orientation codes and the LED segment table of the LED mask block.
// No dependencies.
package tblm_pkg;

  localparam int LED_COUNT = 45;
  localparam int SEG_COUNT = 15;
  localparam int VEC_W     = 15;

  // Orientation as it appears on the result port.
  localparam logic [1:0] ORI_MORNING = 2'd0;
  localparam logic [1:0] ORI_MIDDAY  = 2'd1;
  localparam logic [1:0] ORI_NIGHT   = 2'd2;

  // Stored orientation, one-hot.
  typedef enum logic [2:0] {
    ST_MORNING = 3'b001,
    ST_MIDDAY  = 3'b010,
    ST_NIGHT   = 3'b100
  } orient_t;

  // Decision handed from the decode logic to the mask logic and result register.
  typedef struct packed {
    orient_t    orient;
    logic       start;
    logic       backward;
    logic [2:0] offset;
  } dec_t;

  // Segment spans and, per orientation, which bit of {second, minute, offset}
  // keeps the segment lit.
  localparam logic [5:0] SEG_FIRST [SEG_COUNT] = '{
    6'd7, 6'd14, 6'd0, 6'd31, 6'd29, 6'd27, 6'd21, 6'd23,
    6'd25, 6'd33, 6'd35, 6'd37, 6'd39, 6'd41, 6'd43};
  localparam logic [5:0] SEG_LAST [SEG_COUNT] = '{
    6'd13, 6'd20, 6'd6, 6'd32, 6'd30, 6'd28, 6'd22, 6'd24,
    6'd26, 6'd34, 6'd36, 6'd38, 6'd40, 6'd42, 6'd44};
  localparam logic [3:0] SEL_MORNING [SEG_COUNT] = '{
    4'd2, 4'd0, 4'd1, 4'd12, 4'd11, 4'd10, 4'd9, 4'd3,
    4'd4, 4'd13, 4'd14, 4'd8, 4'd7, 4'd6, 4'd5};
  localparam logic [3:0] SEL_MIDDAY [SEG_COUNT] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
    4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14};
  localparam logic [3:0] SEL_NIGHT [SEG_COUNT] = '{
    4'd1, 4'd2, 4'd0, 4'd7, 4'd8, 4'd14, 4'd13, 4'd12,
    4'd11, 4'd6, 4'd5, 4'd4, 4'd3, 4'd9, 4'd10};

  localparam logic [15:0] MOVE_STEPS_RESET = 16'd200;

  function automatic logic [1:0] orient_code(orient_t o);
    logic [1:0] c;
    unique case (o)
      ST_MORNING: c = ORI_MORNING;
      ST_MIDDAY:  c = ORI_MIDDAY;
      ST_NIGHT:   c = ORI_NIGHT;
      default:    c = ORI_MIDDAY;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/tblm_decode.sv
// Period decode, hour offset and orientation move decision.
// Depends on tblm_pkg.
module tblm_decode (
  input  logic              [4:0] hour,
  input  logic                    motor_busy,
  input  tblm_pkg::orient_t       cur_orient,
  output tblm_pkg::dec_t          dec
);

  tblm_pkg::orient_t target;
  logic [4:0]        offset_full;
  logic              do_move;

  always_comb begin
    if (hour >= 5'd3 && hour < 5'd11) begin
      target      = tblm_pkg::ST_MORNING;
      offset_full = hour - 5'd3;
    end else if (hour >= 5'd11 && hour < 5'd19) begin
      target      = tblm_pkg::ST_MIDDAY;
      offset_full = hour - 5'd11;
    end else if (hour >= 5'd19) begin
      target      = tblm_pkg::ST_NIGHT;
      offset_full = hour - 5'd19;
    end else begin
      target      = tblm_pkg::ST_NIGHT;
      offset_full = hour + 5'd5;
    end
  end

  assign do_move = (cur_orient != target) && !motor_busy;

  always_comb begin
    dec.offset   = offset_full[2:0];
    dec.orient   = do_move ? target : cur_orient;
    dec.start    = do_move;
    // A move is backward when the target is the period that follows the current one.
    dec.backward = 1'b0;
    if (do_move) begin
      unique case (cur_orient)
        tblm_pkg::ST_MORNING: dec.backward = (target == tblm_pkg::ST_MIDDAY);
        tblm_pkg::ST_MIDDAY:  dec.backward = (target == tblm_pkg::ST_NIGHT);
        tblm_pkg::ST_NIGHT:   dec.backward = (target == tblm_pkg::ST_MORNING);
        default:              dec.backward = 1'b0;
      endcase
    end
  end

endmodule

FILE: rtl/tblm_mask.sv
// Segment blanking: builds the LED on/off mask for one orientation.
// Depends on tblm_pkg.
module tblm_mask (
  input  tblm_pkg::orient_t                     orient,
  input  logic              [2:0]               offset,
  input  logic              [5:0]               minute,
  input  logic              [5:0]               second,
  output logic [tblm_pkg::LED_COUNT-1:0]        led_mask
);

  logic [tblm_pkg::VEC_W-1:0] vec;
  logic [3:0]                 sel [tblm_pkg::SEG_COUNT];

  assign vec = {second, minute, offset};

  always_comb begin
    for (int s = 0; s < tblm_pkg::SEG_COUNT; s++) begin
      unique case (orient)
        tblm_pkg::ST_MORNING: sel[s] = tblm_pkg::SEL_MORNING[s];
        tblm_pkg::ST_NIGHT:   sel[s] = tblm_pkg::SEL_NIGHT[s];
        default:              sel[s] = tblm_pkg::SEL_MIDDAY[s];
      endcase
    end
  end

  always_comb begin
    led_mask = '1;
    for (int s = 0; s < tblm_pkg::SEG_COUNT; s++) begin
      for (int i = 0; i < tblm_pkg::LED_COUNT; i++) begin
        if (i >= int'(tblm_pkg::SEG_FIRST[s]) && i <= int'(tblm_pkg::SEG_LAST[s]) &&
            !vec[sel[s]]) begin
          led_mask[i] = 1'b0;
        end
      end
    end
  end

endmodule

FILE: rtl/triangle_binary_clock_led_mask_top.sv
// LED blanking mask and orientation control for a triangular binary clock.
// Depends on tblm_pkg, tblm_decode and tblm_mask.
//
// Usage: each input word carries hour, minute, second and the motor's busy
// flag and is taken at a clock edge where in_valid is high and in_stall low.
// Every input word produces exactly one result word on the out_ channel,
// taken where out_valid is high and out_stall low.
// The result holds the 45-bit LED mask, the orientation after this word and
// a move request (start, direction, step count) for the rotation motor.
//
// The edge that takes the input word loads the input register; the period
// decode and segment blanking logic feed the result register, and out_valid
// rises when it loads. Throughput is one word per cycle while out_stall is
// low; the orientation register is the only state carried between words.
//
// When the receiver stalls, the result register holds its word, the input
// register still takes one more word, and in_stall rises only once both are
// full. Reset (rst_n low, synchronous) empties both stages, sets the
// orientation to midday and the move step count to 200. cfg_we writes
// cfg_wdata into the move step count; write it only while the block is idle.
module triangle_binary_clock_led_mask_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [4:0]  in_hour,
  input  logic [5:0]  in_minute,
  input  logic [5:0]  in_second,
  input  logic        in_motor_busy,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [44:0] out_led_mask,
  output logic [1:0]  out_orientation,
  output logic        out_move_start,
  output logic        out_move_backward,
  output logic [15:0] out_move_steps
);

  // Configuration register.
  logic [15:0] move_step_count_r;

  // Input register.
  logic       s1_valid_r;
  logic [4:0] s1_hour_r;
  logic [5:0] s1_minute_r;
  logic [5:0] s1_second_r;
  logic       s1_busy_r;

  // Orientation state.
  tblm_pkg::orient_t orient_r;

  // Result register.
  logic        out_valid_r;
  logic [44:0] out_led_mask_r;
  logic [1:0]  out_orientation_r;
  logic        out_move_start_r;
  logic        out_move_backward_r;
  logic [15:0] out_move_steps_r;

  tblm_pkg::dec_t                  dec;
  logic [tblm_pkg::LED_COUNT-1:0]  led_mask_nxt;
  logic [15:0]                     move_steps_nxt;
  logic                            advance;
  logic                            load_out;

  // The result register can load when it is empty or its word is leaving.
  assign advance  = !out_valid_r || !out_stall;
  assign load_out = advance && s1_valid_r;
  assign in_stall = s1_valid_r && !advance;

  tblm_decode u_decode (
    .hour       (s1_hour_r),
    .motor_busy (s1_busy_r),
    .cur_orient (orient_r),
    .dec        (dec)
  );

  tblm_mask u_mask (
    .orient   (dec.orient),
    .offset   (dec.offset),
    .minute   (s1_minute_r),
    .second   (s1_second_r),
    .led_mask (led_mask_nxt)
  );

  assign move_steps_nxt = dec.start ? move_step_count_r : 16'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      move_step_count_r <= tblm_pkg::MOVE_STEPS_RESET;
    end else if (cfg_we) begin
      move_step_count_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_hour_r   <= in_hour;
      s1_minute_r <= in_minute;
      s1_second_r <= in_second;
      s1_busy_r   <= in_motor_busy;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      orient_r    <= tblm_pkg::ST_MIDDAY;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (load_out) begin
        orient_r <= dec.orient;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_led_mask_r      <= led_mask_nxt;
      out_orientation_r   <= tblm_pkg::orient_code(dec.orient);
      out_move_start_r    <= dec.start;
      out_move_backward_r <= dec.backward;
      out_move_steps_r    <= move_steps_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_led_mask      = out_led_mask_r;
  assign out_orientation   = out_orientation_r;
  assign out_move_start    = out_move_start_r;
  assign out_move_backward = out_move_backward_r;
  assign out_move_steps    = out_move_steps_r;

endmodule

FILE: rtl/tblm_chk.sv
// Port-level checker for the LED mask block, bound to the top level.
// Depends on triangle_binary_clock_led_mask_top_defines.svh and tblm_pkg.
`include "triangle_binary_clock_led_mask_top_defines.svh"

module tblm_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_we,
  input logic [15:0] cfg_wdata,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [44:0] out_led_mask,
  input logic [1:0]  out_orientation,
  input logic        out_move_start,
  input logic        out_move_backward,
  input logic [15:0] out_move_steps
);

  // Shadow copy of the step count register, built from the port alone.
  logic [15:0] steps_shadow_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_shadow_r <= tblm_pkg::MOVE_STEPS_RESET;
    end else if (cfg_we) begin
      steps_shadow_r <= cfg_wdata;
    end
  end

  // A stalled result word stays in place.
  `TBLM_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_led_mask) && $stable(out_orientation) && $stable(out_move_steps))

  // The input side only backs up when the result side is full and stalled.
  `TBLM_ASSERT_NOW(a_in_stall_cause, in_stall,
    out_valid && out_stall && in_valid || in_stall && out_valid && out_stall)

  // Without a move request, direction and step count read zero.
  `TBLM_ASSERT_NOW(a_idle_move_zero, out_valid && !out_move_start,
    !out_move_backward && out_move_steps == 16'd0)

  // A move request carries the configured step count.
  `TBLM_ASSERT_NOW(a_move_steps, out_valid && out_move_start, out_move_steps == steps_shadow_r)

endmodule

bind triangle_binary_clock_led_mask_top tblm_chk u_tblm_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .cfg_we            (cfg_we),
  .cfg_wdata         (cfg_wdata),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_led_mask      (out_led_mask),
  .out_orientation   (out_orientation),
  .out_move_start    (out_move_start),
  .out_move_backward (out_move_backward),
  .out_move_steps    (out_move_steps)
);
